// ===== design/voxel_face_quad_ao_emitter_core_macros.svh =====
// assertion helpers used by the core module
`ifndef VOXEL_FACE_QUAD_AO_EMITTER_CORE_MACROS_SVH
`define VOXEL_FACE_QUAD_AO_EMITTER_CORE_MACROS_SVH

// same-cycle implication, held off during reset
`define VFQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vfq assertion failed");

// next-cycle implication, held off during reset
`define VFQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vfq assertion failed");

`endif

// ===== design/vfq_pkg.sv =====
package vfq_pkg;

    // chunk size, positions at or beyond it are saturated
    localparam int CHUNK_EDGE = 16;

    localparam int POS_W       = 4;
    localparam int VIS_W       = 6;
    localparam int NB_W        = 27;
    localparam int NB_IDX_W    = 5;
    localparam int VTX_W       = 5;
    localparam int FACE_W      = 3;
    localparam int CORNER_W    = 2;
    localparam int LEVEL_W     = 3;
    localparam int LIGHT_W     = 9;
    localparam int AO_W        = 8;
    localparam int PROD_W      = LIGHT_W + AO_W;
    localparam int CFG_IDX_W   = 2;

    localparam int NUM_FACES   = 6;
    localparam int NUM_CORNERS = 4;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [LIGHT_W-1:0] LIGHT_MAX        = 9'd256;
    localparam logic [LIGHT_W-1:0] LIGHT_TOP_RST    = 9'd256;
    localparam logic [LIGHT_W-1:0] LIGHT_BOTTOM_RST = 9'd141;
    localparam logic [LIGHT_W-1:0] LIGHT_SIDE_X_RST = 9'd218;
    localparam logic [LIGHT_W-1:0] LIGHT_SIDE_Z_RST = 9'd179;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LIGHT_TOP,
        REG_LIGHT_BOTTOM,
        REG_LIGHT_SIDE_X,
        REG_LIGHT_SIDE_Z
    } t_reg_idx;

    localparam logic [FACE_W-1:0] FACE_XP = 3'd0;
    localparam logic [FACE_W-1:0] FACE_XN = 3'd1;
    localparam logic [FACE_W-1:0] FACE_YP = 3'd2;
    localparam logic [FACE_W-1:0] FACE_YN = 3'd3;
    localparam logic [FACE_W-1:0] FACE_ZP = 3'd4;
    localparam logic [FACE_W-1:0] FACE_ZN = 3'd5;

    // corner direction per face and corner, bit set means +1 on that axis
    // bit 0 x, bit 1 y, bit 2 z
    localparam logic [2:0] CORNER_DIR [NUM_FACES][NUM_CORNERS] = '{
        '{3'b101, 3'b001, 3'b011, 3'b111},
        '{3'b000, 3'b100, 3'b110, 3'b010},
        '{3'b011, 3'b010, 3'b110, 3'b111},
        '{3'b000, 3'b001, 3'b101, 3'b100},
        '{3'b100, 3'b101, 3'b111, 3'b110},
        '{3'b001, 3'b000, 3'b010, 3'b011}
    };

    // one cube as held in the queue, position already saturated
    typedef struct packed {
        logic [POS_W-1:0] px;
        logic [POS_W-1:0] py;
        logic [POS_W-1:0] pz;
        logic [VIS_W-1:0] vis;
        logic [NB_W-1:0]  nb;
    } t_cube;

    typedef struct packed {
        logic [LIGHT_W-1:0] top;
        logic [LIGHT_W-1:0] bottom;
        logic [LIGHT_W-1:0] side_x;
        logic [LIGHT_W-1:0] side_z;
    } t_lights;

    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_stat;

    // q0.8 occlusion value per level
    function automatic logic [AO_W-1:0] ao_value(input logic [LEVEL_W-1:0] level);
        logic [AO_W-1:0] v;
        case (level)
            3'd1:    v = 8'd107;
            3'd2:    v = 8'd149;
            3'd3:    v = 8'd192;
            3'd4:    v = 8'd235;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    // neighbour bit from per-axis codes 0/1/2 for offset -1/0/+1
    function automatic logic [NB_IDX_W-1:0] nb_index(input logic [1:0] cx,
                                                     input logic [1:0] cy,
                                                     input logic [1:0] cz);
        return NB_IDX_W'(9 * int'(cx) + 3 * int'(cy) + int'(cz));
    endfunction

endpackage

// ===== design/vfq_cube_if.sv =====
interface vfq_cube_if import vfq_pkg::*;;
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] block_x;
    logic [POS_W-1:0] block_y;
    logic [POS_W-1:0] block_z;
    logic [VIS_W-1:0] face_visible;
    logic [NB_W-1:0]  neighbor_solid;

    modport source (
        output valid, block_x, block_y, block_z, face_visible, neighbor_solid,
        input  ready
    );

    modport sink (
        input  valid, block_x, block_y, block_z, face_visible, neighbor_solid,
        output ready
    );
endinterface

// ===== design/vfq_vertex_if.sv =====
interface vfq_vertex_if import vfq_pkg::*;;
    logic                valid;
    logic                ready;
    logic [FACE_W-1:0]   face_index;
    logic [CORNER_W-1:0] corner_index;
    logic [VTX_W-1:0]    vertex_x;
    logic [VTX_W-1:0]    vertex_y;
    logic [VTX_W-1:0]    vertex_z;
    logic [LEVEL_W-1:0]  occlusion_level;
    logic [LIGHT_W-1:0]  brightness;
    logic                last_vertex;

    modport source (
        output valid, face_index, corner_index, vertex_x, vertex_y, vertex_z,
               occlusion_level, brightness, last_vertex,
        input  ready
    );

    modport sink (
        input  valid, face_index, corner_index, vertex_x, vertex_y, vertex_z,
               occlusion_level, brightness, last_vertex,
        output ready
    );
endinterface

// ===== design/voxel_face_quad_ao_emitter_core.sv =====
// path: a taken cube is written into the queue, and when the back is idle its first
//   vertex is then registered in the output register for the sink to take
// throughput: one vertex per cycle from the back sequencer while the sink is ready,
//   4 per exposed face, 24 with all six faces exposed
// a cube with no exposed face is taken in, dropped by the front and produces nothing
// reset (synchronous, active low) empties the cube queue and output register
//   and loads the light registers with 256, 141, 218 and 179
`include "voxel_face_quad_ao_emitter_core_macros.svh"

module voxel_face_quad_ao_emitter_core import vfq_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    vfq_cube_if.sink             i_item,
    vfq_vertex_if.source         o_vertex,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [LIGHT_W-1:0]   i_cfg_data
);

    // light registers keep the written bits, saturation to 256 happens in the back end
    logic [LIGHT_W-1:0] r_light_top;
    logic [LIGHT_W-1:0] r_light_bottom;
    logic [LIGHT_W-1:0] r_light_side_x;
    logic [LIGHT_W-1:0] r_light_side_z;
    t_lights            lights;

    // front to queue
    logic    q_push;
    t_cube   q_push_data;
    // queue to back
    t_cube   q_head;
    t_q_stat q_stat;
    logic    q_pop;

    // views of the output used by the checks below
    logic    out_last;
    logic    out_corner_last;
    logic    out_level_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_top    <= LIGHT_TOP_RST;
            r_light_bottom <= LIGHT_BOTTOM_RST;
            r_light_side_x <= LIGHT_SIDE_X_RST;
            r_light_side_z <= LIGHT_SIDE_Z_RST;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_LIGHT_TOP:    r_light_top    <= i_cfg_data;
                REG_LIGHT_BOTTOM: r_light_bottom <= i_cfg_data;
                REG_LIGHT_SIDE_X: r_light_side_x <= i_cfg_data;
                REG_LIGHT_SIDE_Z: r_light_side_z <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign lights.top    = r_light_top;
    assign lights.bottom = r_light_bottom;
    assign lights.side_x = r_light_side_x;
    assign lights.side_z = r_light_side_z;

    // front: takes cubes, saturates the position, drops cubes with nothing to draw
    vfq_front u_front (
        .i_item      (i_item),
        .i_q_stat    (q_stat),
        .o_push      (q_push),
        .o_push_data (q_push_data)
    );

    // short queue so the front keeps taking cubes while the back is emitting
    vfq_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .i_pop       (q_pop),
        .o_head      (q_head),
        .o_stat      (q_stat)
    );

    // back: walks exposed faces and corners of the head cube, one vertex per cycle while
    // the output register is free or taken, and pops the cube with its final vertex
    vfq_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (q_head),
        .i_q_stat (q_stat),
        .i_lights (lights),
        .o_pop    (q_pop),
        .o_vertex (o_vertex)
    );

    assign out_last        = o_vertex.valid && o_vertex.last_vertex;
    assign out_corner_last = (o_vertex.corner_index == CORNER_W'(NUM_CORNERS - 1));
    assign out_level_ok    = (o_vertex.occlusion_level >= 3'd1)
                          && (o_vertex.occlusion_level <= 3'd4);

    // popping a cube means its final vertex sits in the output register next cycle
    `VFQ_ASSERT_NEXT(a_pop_gives_last, i_clk, i_rst_n, q_pop, out_last)
    // the final vertex of a cube always closes a quad
    `VFQ_ASSERT_IMPLY(a_last_on_corner, i_clk, i_rst_n, out_last, out_corner_last)
    // occlusion level stays within one to four
    `VFQ_ASSERT_IMPLY(a_level_range, i_clk, i_rst_n, o_vertex.valid, out_level_ok)

endmodule

// ===== design/vfq_front.sv =====
module vfq_front import vfq_pkg::*; (
    vfq_cube_if.sink i_item,
    input  t_q_stat  i_q_stat,
    output logic     o_push,
    output t_cube    o_push_data
);

    localparam int POS_MAX = CHUNK_EDGE - 1;

    function automatic logic [POS_W-1:0] clamp_pos(input logic [POS_W-1:0] p);
        logic [POS_W-1:0] r;
        r = p;
        if ({2'b00, p} > 6'(POS_MAX)) begin
            r = POS_W'(POS_MAX);
        end
        return r;
    endfunction

    assign i_item.ready = !i_q_stat.full;

    // cubes with no exposed face are taken and dropped here
    assign o_push = i_item.valid && i_item.ready && (i_item.face_visible != '0);

    assign o_push_data.px  = clamp_pos(i_item.block_x);
    assign o_push_data.py  = clamp_pos(i_item.block_y);
    assign o_push_data.pz  = clamp_pos(i_item.block_z);
    assign o_push_data.vis = i_item.face_visible;
    assign o_push_data.nb  = i_item.neighbor_solid;

endmodule

// ===== design/vfq_queue.sv =====
module vfq_queue import vfq_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cube   i_push_data,
    input  logic    i_pop,
    output t_cube   o_head,
    output t_q_stat o_stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cube              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_head           = r_mem[r_rd_ptr];
    assign o_stat.full      = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_stat.not_empty = (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ===== design/vfq_back.sv =====
module vfq_back import vfq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cube             i_head,
    input  t_q_stat           i_q_stat,
    input  t_lights           i_lights,
    output logic              o_pop,
    vfq_vertex_if.source      o_vertex
);

    localparam logic [CORNER_W-1:0] LAST_CORNER = CORNER_W'(NUM_CORNERS - 1);

    // faces of the head cube already emitted
    logic [VIS_W-1:0]    r_done;
    logic [CORNER_W-1:0] r_corner;

    logic                r_out_valid;
    logic [FACE_W-1:0]   r_face;
    logic [CORNER_W-1:0] r_corner_out;
    logic [VTX_W-1:0]    r_vx;
    logic [VTX_W-1:0]    r_vy;
    logic [VTX_W-1:0]    r_vz;
    logic [LEVEL_W-1:0]  r_level;
    logic [LIGHT_W-1:0]  r_bright;
    logic                r_last;

    logic [VIS_W-1:0]    rem;
    logic [VIS_W-1:0]    face_bit;
    logic [FACE_W-1:0]   face;
    logic [2:0]          dir;
    logic [1:0]          ax;
    logic [1:0]          t1;
    logic [1:0]          t2;
    logic [1:0]          code [3];
    logic [1:0]          s1 [3];
    logic [1:0]          s2 [3];
    logic                sa;
    logic                sb;
    logic                sk;
    logic [LEVEL_W-1:0]  level;
    logic [LIGHT_W-1:0]  light;
    logic [PROD_W-1:0]   prod;
    logic [VTX_W-1:0]    vx;
    logic [VTX_W-1:0]    vy;
    logic [VTX_W-1:0]    vz;
    logic                last;
    logic                advance;

    always_comb begin
        rem  = i_head.vis & ~r_done;
        face = '0;
        for (int i = NUM_FACES - 1; i >= 0; i--) begin
            if (rem[i]) begin
                face = FACE_W'(i);
            end
        end
        face_bit = VIS_W'(1) << face;
        last     = (r_corner == LAST_CORNER) && ((rem & ~face_bit) == '0);

        dir = CORNER_DIR[face][r_corner];
        ax  = face[2:1];
        case (ax)
            2'd0:    begin t1 = 2'd1; t2 = 2'd2; end
            2'd1:    begin t1 = 2'd2; t2 = 2'd0; end
            default: begin t1 = 2'd0; t2 = 2'd1; end
        endcase
        for (int j = 0; j < 3; j++) begin
            code[j] = dir[j] ? 2'd2 : 2'd0;
            s1[j]   = code[j];
            s2[j]   = code[j];
        end
        s1[t1] = 2'd1;
        s2[t2] = 2'd1;

        sa = i_head.nb[nb_index(s1[0], s1[1], s1[2])];
        sb = i_head.nb[nb_index(s2[0], s2[1], s2[2])];
        sk = i_head.nb[nb_index(code[0], code[1], code[2])];
        if (sa && sb) begin
            level = 3'd1;
        end else begin
            level = 3'd4 - {2'b00, sa} - {2'b00, sb} - {2'b00, sk};
        end

        case (face)
            FACE_YP:          light = i_lights.top;
            FACE_YN:          light = i_lights.bottom;
            FACE_XP, FACE_XN: light = i_lights.side_x;
            default:          light = i_lights.side_z;
        endcase
        if (light > LIGHT_MAX) begin
            light = LIGHT_MAX;
        end
        prod = PROD_W'(light) * PROD_W'(ao_value(level)) + PROD_W'(128);

        vx = {1'b0, i_head.px} + VTX_W'(dir[0]);
        vy = {1'b0, i_head.py} + VTX_W'(dir[1]);
        vz = {1'b0, i_head.pz} + VTX_W'(dir[2]);
    end

    assign advance = i_q_stat.not_empty && (!r_out_valid || o_vertex.ready);
    assign o_pop   = advance && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_done      <= '0;
            r_corner    <= '0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                if (r_corner == LAST_CORNER) begin
                    r_corner <= '0;
                    r_done   <= last ? '0 : (r_done | face_bit);
                end else begin
                    r_corner <= r_corner + 1'b1;
                end
            end else if (o_vertex.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_face       <= face;
            r_corner_out <= r_corner;
            r_vx         <= vx;
            r_vy         <= vy;
            r_vz         <= vz;
            r_level      <= level;
            r_bright     <= prod[PROD_W-1:AO_W];
            r_last       <= last;
        end
    end

    assign o_vertex.valid           = r_out_valid;
    assign o_vertex.face_index      = r_face;
    assign o_vertex.corner_index    = r_corner_out;
    assign o_vertex.vertex_x        = r_vx;
    assign o_vertex.vertex_y        = r_vy;
    assign o_vertex.vertex_z        = r_vz;
    assign o_vertex.occlusion_level = r_level;
    assign o_vertex.brightness      = r_bright;
    assign o_vertex.last_vertex     = r_last;

endmodule

// ===== tb/testbench.sv =====
module testbench;
    import vfq_pkg::*;

    // cycles with no item moving on either channel before the run is abandoned
    localparam int IDLE_LIMIT    = 2000;
    // cycles to let the block settle after the last vertex
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 43;

    // one vertex as it leaves the block
    typedef struct packed {
        logic [FACE_W-1:0]   face;
        logic [CORNER_W-1:0] corner;
        logic [VTX_W-1:0]    vx;
        logic [VTX_W-1:0]    vy;
        logic [VTX_W-1:0]    vz;
        logic [LEVEL_W-1:0]  level;
        logic [LIGHT_W-1:0]  bright;
        logic                last;
    } t_vertex;

    // predicts the vertex stream of each cube and checks the block against it
    class vertex_scoreboard;
        t_vertex            pending[$];
        logic [LIGHT_W-1:0] light_reg [4];
        int                 errors;

        function new();
            light_reg[REG_LIGHT_TOP]    = 9'd256;
            light_reg[REG_LIGHT_BOTTOM] = 9'd141;
            light_reg[REG_LIGHT_SIDE_X] = 9'd218;
            light_reg[REG_LIGHT_SIDE_Z] = 9'd179;
            errors = 0;
        endfunction

        function void set_light(t_reg_idx idx, logic [LIGHT_W-1:0] value);
            light_reg[idx] = value;
        endfunction

        // expands one accepted cube into its expected vertices
        function void note_cube(t_cube c);
            // bit set means +1 on that axis: bit 0 x, bit 1 y, bit 2 z
            logic [2:0] sign_tab [6][4] = '{
                '{3'b101, 3'b001, 3'b011, 3'b111},
                '{3'b000, 3'b100, 3'b110, 3'b010},
                '{3'b011, 3'b010, 3'b110, 3'b111},
                '{3'b000, 3'b001, 3'b101, 3'b100},
                '{3'b100, 3'b101, 3'b111, 3'b110},
                '{3'b001, 3'b000, 3'b010, 3'b011}
            };
            int         code [3];
            int         side1 [3];
            int         side2 [3];
            int         ax, t1, t2, lvl, lit, occl, emitted;
            logic       s1_solid, s2_solid, diag_solid;
            logic [2:0] sgn;
            t_vertex    v;
            emitted = 0;
            for (int f = 0; f < NUM_FACES; f++) begin
                if (!c.vis[f])
                    continue;
                case (f)
                    FACE_YP:          lit = light_reg[REG_LIGHT_TOP];
                    FACE_YN:          lit = light_reg[REG_LIGHT_BOTTOM];
                    FACE_XP, FACE_XN: lit = light_reg[REG_LIGHT_SIDE_X];
                    default:          lit = light_reg[REG_LIGHT_SIDE_Z];
                endcase
                if (lit > 256)
                    lit = 256;
                ax = f / 2;
                t1 = (ax + 1) % 3;
                t2 = (ax + 2) % 3;
                for (int cn = 0; cn < NUM_CORNERS; cn++) begin
                    sgn = sign_tab[f][cn];
                    for (int a = 0; a < 3; a++)
                        code[a] = sgn[a] ? 2 : 0;
                    side1 = code;
                    side2 = code;
                    side1[t1] = 1;
                    side2[t2] = 1;
                    s1_solid   = c.nb[9 * side1[0] + 3 * side1[1] + side1[2]];
                    s2_solid   = c.nb[9 * side2[0] + 3 * side2[1] + side2[2]];
                    diag_solid = c.nb[9 * code[0] + 3 * code[1] + code[2]];
                    lvl = (s1_solid && s2_solid) ? 1
                        : 4 - (int'(s1_solid) + int'(s2_solid) + int'(diag_solid));
                    case (lvl)
                        1:       occl = 107;
                        2:       occl = 149;
                        3:       occl = 192;
                        default: occl = 235;
                    endcase
                    v.face   = FACE_W'(f);
                    v.corner = CORNER_W'(cn);
                    v.vx     = VTX_W'(c.px) + VTX_W'(sgn[0]);
                    v.vy     = VTX_W'(c.py) + VTX_W'(sgn[1]);
                    v.vz     = VTX_W'(c.pz) + VTX_W'(sgn[2]);
                    v.level  = LEVEL_W'(lvl);
                    v.bright = LIGHT_W'((lit * occl + 128) >> 8);
                    v.last   = 1'b0;
                    pending.push_back(v);
                    emitted++;
                end
            end
            if (emitted > 0)
                pending[pending.size() - 1].last = 1'b1;
        endfunction

        function void compare_field(string name, int expd, int got);
            if (expd != got) begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expd, got);
                errors++;
            end
        endfunction

        function void check_vertex(t_vertex got);
            t_vertex expd;
            if (pending.size() == 0) begin
                $display("%0t: unexpected vertex, expected none, got %h", $time, got);
                errors++;
                return;
            end
            expd = pending.pop_front();
            compare_field("face_index", expd.face, got.face);
            compare_field("corner_index", expd.corner, got.corner);
            compare_field("vertex_x", expd.vx, got.vx);
            compare_field("vertex_y", expd.vy, got.vy);
            compare_field("vertex_z", expd.vz, got.vz);
            compare_field("occlusion_level", expd.level, got.level);
            compare_field("brightness", expd.bright, got.bright);
            compare_field("last_vertex", expd.last, got.last);
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [LIGHT_W-1:0]   i_cfg_data;

    vfq_cube_if   cube_if ();
    vfq_vertex_if vtx_if ();

    vertex_scoreboard board;
    // random idling on both channels, switched off for the closing phase
    bit               idling_on;
    int               idle_count;

    voxel_face_quad_ao_emitter_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (cube_if),
        .o_vertex   (vtx_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // random cube, every field over its full range
    function automatic t_cube rand_cube();
        t_cube c;
        c.px  = POS_W'($urandom_range(0, 15));
        c.py  = POS_W'($urandom_range(0, 15));
        c.pz  = POS_W'($urandom_range(0, 15));
        c.vis = VIS_W'($urandom_range(0, 63));
        c.nb  = NB_W'($urandom);
        return c;
    endfunction

    function automatic t_cube make_cube(int x, int y, int z, int vis, logic [NB_W-1:0] nb);
        t_cube c;
        c.px  = POS_W'(x);
        c.py  = POS_W'(y);
        c.pz  = POS_W'(z);
        c.vis = VIS_W'(vis);
        c.nb  = nb;
        return c;
    endfunction

    // drives one cube at the falling edge and holds it until taken;
    // returns at the rising edge that accepted it
    task automatic send_cube(t_cube c);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 17)) begin
                @(negedge i_clk);
                cube_if.valid = 1'b0;
            end
        end
        @(negedge i_clk);
        cube_if.valid          = 1'b1;
        cube_if.block_x        = c.px;
        cube_if.block_y        = c.py;
        cube_if.block_z        = c.pz;
        cube_if.face_visible   = c.vis;
        cube_if.neighbor_solid = c.nb;
        do @(posedge i_clk); while (!cube_if.ready);
        board.note_cube(c);
    endtask

    // holds the sender back until every expected vertex is out, then lets
    // the block settle
    task automatic drain();
        @(negedge i_clk);
        cube_if.valid = 1'b0;
        while (board.pending.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_light(t_reg_idx idx, logic [LIGHT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        board.set_light(idx, value);
    endtask

    task automatic set_lights(int top, int bottom, int side_x, int side_z);
        write_light(REG_LIGHT_TOP, LIGHT_W'(top));
        write_light(REG_LIGHT_BOTTOM, LIGHT_W'(bottom));
        write_light(REG_LIGHT_SIDE_X, LIGHT_W'(side_x));
        write_light(REG_LIGHT_SIDE_Z, LIGHT_W'(side_z));
    endtask

    task automatic send_random(int count);
        for (int i = 0; i < count; i++)
            send_cube(rand_cube());
    endtask

    // receiver: ready drops in random bursts while idling is on
    initial begin
        int stall_left;
        stall_left   = 0;
        vtx_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idling_on && stall_left > 0) begin
                vtx_if.ready = 1'b0;
                stall_left--;
            end else if (idling_on && $urandom_range(0, 6) == 0) begin
                vtx_if.ready = 1'b0;
                stall_left   = $urandom_range(1, 17) - 1;
            end else begin
                vtx_if.ready = 1'b1;
            end
        end
    end

    // output check and watchdog, both sampled at the rising edge
    always @(posedge i_clk) begin
        t_vertex got;
        if (i_rst_n && vtx_if.valid && vtx_if.ready) begin
            got.face   = vtx_if.face_index;
            got.corner = vtx_if.corner_index;
            got.vx     = vtx_if.vertex_x;
            got.vy     = vtx_if.vertex_y;
            got.vz     = vtx_if.vertex_z;
            got.level  = vtx_if.occlusion_level;
            got.bright = vtx_if.brightness;
            got.last   = vtx_if.last_vertex;
            board.check_vertex(got);
        end
        if ((cube_if.valid && cube_if.ready) || (vtx_if.valid && vtx_if.ready))
            idle_count = 0;
        else
            idle_count++;
        if (idle_count >= IDLE_LIMIT) begin
            $display("voxel_face_quad_ao_emitter_core test failed");
            $finish;
        end
    end

    initial begin
        board                  = new();
        idle_count             = 0;
        idling_on              = 1'b1;
        i_rst_n                = 1'b0;
        i_cfg_we               = 1'b0;
        i_cfg_idx              = REG_LIGHT_TOP;
        i_cfg_data             = '0;
        cube_if.valid          = 1'b0;
        cube_if.block_x        = '0;
        cube_if.block_y        = '0;
        cube_if.block_z        = '0;
        cube_if.face_visible   = '0;
        cube_if.neighbor_solid = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed cubes at the reset light levels
        // no exposed face gives no vertex, straight after it a full cube
        send_cube(make_cube(0, 0, 0, 0, '0));
        send_cube(make_cube(0, 0, 0, 63, '0));
        send_cube(make_cube(15, 15, 15, 63, '1));
        // each face on its own
        for (int f = 0; f < NUM_FACES; f++)
            send_cube(make_cube($urandom_range(0, 15), $urandom_range(0, 15),
                                $urandom_range(0, 15), 1 << f, NB_W'($urandom)));
        // the centre neighbour must never be looked at
        send_cube(make_cube(7, 8, 9, 63, 27'h0002000));
        send_cube(make_cube(15, 0, 15, 63, 27'h7FFDFFF));
        send_cube(make_cube(0, 15, 0, 63, 27'h5555555));
        send_cube(make_cube(15, 15, 0, 63, 27'h2AAAAAA));
        send_cube(make_cube(15, 15, 15, 0, '1));
        send_cube(make_cube(3, 12, 5, 6'h2A, NB_W'($urandom)));
        send_cube(make_cube(12, 3, 10, 6'h15, NB_W'($urandom)));
        send_random(4);

        // light extremes, then saturation above 256, then random settings
        drain();
        set_lights(256, 256, 256, 256);
        send_random(PHASE_ITEMS);
        drain();
        set_lights(0, 0, 0, 0);
        send_random(PHASE_ITEMS);
        drain();
        set_lights(511, 257, 300, 384);
        send_random(PHASE_ITEMS);
        drain();
        set_lights($urandom_range(0, 256), $urandom_range(0, 256),
                   $urandom_range(0, 256), $urandom_range(0, 256));
        send_random(PHASE_ITEMS);
        drain();
        set_lights($urandom_range(0, 511), $urandom_range(0, 511),
                   $urandom_range(0, 511), $urandom_range(0, 511));
        send_random(PHASE_ITEMS);

        // closing phase at full rate on both sides
        drain();
        idling_on = 1'b0;
        set_lights($urandom_range(1, 255), $urandom_range(1, 255),
                   $urandom_range(257, 511), 256);
        send_random(PHASE_ITEMS);

        drain();
        if (board.errors == 0)
            $display("voxel_face_quad_ao_emitter_core test passed");
        else
            $display("voxel_face_quad_ao_emitter_core test failed");
        $finish;
    end
endmodule
